// File: design/srb_pkg.sv
// Shared types and codes for the sequence reorder buffer.
`timescale 1ns / 1ps
package srb_pkg;

  typedef enum logic [2:0] {
    OC_DIRECT    = 3'd0,
    OC_BUFFERED  = 3'd1,
    OC_OLD       = 3'd2,
    OC_OUTSIDE   = 3'd3,
    OC_DUPLICATE = 3'd4,
    OC_RELEASED  = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [15:0] seq_id;
    logic [15:0] reliable_id;
    logic [31:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] out_seq;
    logic [15:0] out_reliable;
    logic [31:0] out_payload;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic do_clear;
    logic do_accept;
    logic do_decide;
    logic do_release;
  } srb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic direct;
    logic more;
  } srb_stat_t;

endpackage

// File: design/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer.
`timescale 1ns / 1ps
// Delivers messages strictly in sequence-number order.
// Input: drive in_item with start high; the transfer happens at a rising edge where
// busy is low. An arrival equal to the expected number is delivered, then every
// parked successor that follows without a gap is released, one per cycle. An arrival
// 1 to WINDOW_DEPTH-1 ahead parks in its slot if free; others are dropped and flagged.
// Output: each result shows on out_item for one cycle with out_valid high; the
// receiver cannot stall it. out_item.last marks the final result of an arrival.
// The transfer registers the arrival; the decide state then judges it and registers
// the first result onto out_item.
// Busy stays high, so no new arrival is taken, until the decide state and any releases
// for the last one are done, up to WINDOW_DEPTH-1 releases; they are paced by the
// single read port of the slot memory, read one slot ahead per release.
// Reset: clears the expected number to zero, then a clearing pass writes each slot
// in turn to mark every slot empty; busy stays high until it ends.
module sequence_reorder_buffer #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srb_pkg::in_item_t  in_item,
  output logic               out_valid,
  output srb_pkg::out_item_t out_item
);
  import srb_pkg::*;

  srb_cmd_t  cmd;
  srb_stat_t stat;

  srb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  srb_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: design/srb_ctrl.sv
// Controller state machine for the sequence reorder buffer.
`timescale 1ns / 1ps
module srb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t  cmd,
  output logic               busy
);
  import srb_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_RELEASE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (stat.direct && stat.more) ? ST_RELEASE : ST_IDLE;
      end
      ST_RELEASE: begin
        if (!stat.more) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.do_clear   = (state_r == ST_CLEAR);
    cmd.do_accept  = (state_r == ST_IDLE) && start;
    cmd.do_decide  = (state_r == ST_DECIDE);
    cmd.do_release = (state_r == ST_RELEASE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: design/srb_datapath.sv
// Datapath of the sequence reorder buffer: slot memory, sequence tracking, result register.
`timescale 1ns / 1ps
module srb_datapath #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srb_pkg::srb_cmd_t  cmd,
  input  srb_pkg::in_item_t  in_item,
  output srb_pkg::srb_stat_t stat,
  output logic               out_valid,
  output srb_pkg::out_item_t out_item
);
  import srb_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(WINDOW_DEPTH);
  localparam logic [15:0]       DEPTH_16  = 16'(WINDOW_DEPTH);

  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    logic [15:0] rel;
    logic [31:0] payload;
  } slot_word_t;

  // Slot after the one holding seq; sequence wrap restarts the slot count at zero
  function automatic logic [SLOT_W-1:0] adv_slot(input logic [SLOT_W-1:0] slot,
                                                 input logic [15:0] seq);
    logic [SLOT_W-1:0] res;
    if (seq == 16'hFFFF || slot == SLOT_LAST) res = '0;
    else res = slot + 1'b1;
    return res;
  endfunction

  slot_word_t mem [WINDOW_DEPTH];
  slot_word_t rd_r;

  logic [15:0]       expected_r;
  logic [SLOT_W-1:0] exp_slot_r;
  logic [SLOT_W-1:0] look_slot_r;
  logic [15:0]       look_seq_r;
  in_item_t          in_r;
  logic [47:0]       hold_r;
  logic [SLOT_W-1:0] count_r;
  logic [SLOT_W-1:0] clr_idx_r;
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         out_nxt;

  logic [15:0]       dist_acc;
  logic [15:0]       dist_dec;
  logic [SLOT_W:0]   park_sum;
  logic [SLOT_W-1:0] park_slot;
  logic [SLOT_W-1:0] rd_addr;
  logic              cand_match;
  logic              more;
  logic              direct;
  logic              park_ok;
  logic              we;
  logic [SLOT_W-1:0] wr_addr;
  slot_word_t        wr_data;

  assign dist_acc = in_item.seq_id - expected_r;
  assign dist_dec = in_r.seq_id - expected_r;

  // Parking slot: an arrival that wrapped past zero is below the depth, so it is its own slot
  always_comb begin
    park_sum = {1'b0, exp_slot_r} + {1'b0, dist_acc[SLOT_W-1:0]};
    if (park_sum >= DEPTH_EXT) park_sum = park_sum - DEPTH_EXT;
    if (in_item.seq_id < expected_r) park_slot = in_item.seq_id[SLOT_W-1:0];
    else park_slot = park_sum[SLOT_W-1:0];
  end

  always_comb begin
    if (cmd.do_accept) begin
      rd_addr = (dist_acc == 16'd0) ? adv_slot(exp_slot_r, expected_r) : park_slot;
    end else begin
      rd_addr = adv_slot(look_slot_r, look_seq_r);
    end
  end

  assign cand_match = rd_r.valid && (rd_r.seq == look_seq_r);
  assign more       = cand_match && (count_r < SLOT_LAST);
  assign direct     = (dist_dec == 16'd0);
  assign park_ok    = !direct && !dist_dec[15] && (dist_dec < DEPTH_16) && !rd_r.valid;

  always_comb begin
    stat            = '0;
    stat.clear_done = (clr_idx_r == SLOT_LAST);
    stat.direct     = direct;
    stat.more       = more;
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = clr_idx_r;
    wr_data = '0;
    if (cmd.do_clear) begin
      we = 1'b1;
    end else if (cmd.do_decide && park_ok) begin
      we      = 1'b1;
      wr_addr = look_slot_r;
      wr_data = '{valid: 1'b1, seq: in_r.seq_id, rel: in_r.reliable_id,
                  payload: in_r.payload_tag};
    end else if (cmd.do_release) begin
      we      = 1'b1;
      wr_addr = exp_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.out_seq      = in_r.seq_id;
    out_nxt.out_reliable = in_r.reliable_id;
    out_nxt.out_payload  = in_r.payload_tag;
    out_nxt.last         = 1'b1;
    if (cmd.do_release) begin
      out_nxt.outcome      = OC_RELEASED;
      out_nxt.out_seq      = expected_r;
      out_nxt.out_reliable = hold_r[47:32];
      out_nxt.out_payload  = hold_r[31:0];
      out_nxt.last         = !more;
    end else if (direct) begin
      out_nxt.outcome = OC_DIRECT;
      out_nxt.last    = !more;
    end else if (dist_dec[15]) begin
      out_nxt.outcome = OC_OLD;
    end else if (dist_dec >= DEPTH_16) begin
      out_nxt.outcome = OC_OUTSIDE;
    end else if (rd_r.valid) begin
      out_nxt.outcome = (rd_r.seq == in_r.seq_id) ? OC_DUPLICATE : OC_OUTSIDE;
    end else begin
      out_nxt.outcome = OC_BUFFERED;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.do_accept) in_r <= in_item;
    if (cmd.do_decide || cmd.do_release) begin
      hold_r <= {rd_r.rel, rd_r.payload};
      out_r  <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      exp_slot_r  <= '0;
      look_slot_r <= '0;
      look_seq_r  <= '0;
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.do_decide || cmd.do_release;
      if (cmd.do_clear) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.do_accept) begin
        look_slot_r <= rd_addr;
        look_seq_r  <= expected_r + 16'd1;
        count_r     <= '0;
      end
      if (cmd.do_decide || cmd.do_release) begin
        look_slot_r <= rd_addr;
        look_seq_r  <= look_seq_r + 16'd1;
      end
      // Advance the expected number past the message just delivered
      if ((cmd.do_decide && direct) || cmd.do_release) begin
        expected_r <= look_seq_r;
        exp_slot_r <= look_slot_r;
        count_r    <= count_r + 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
